// ----- rtl/core/subtractive_lagged_random_core_assert.svh -----
// ----------------------------------------------------------------------------
// Subtractive random core assertion macros
// Shared property forms for the checker of the subtractive random core.
// ----------------------------------------------------------------------------
`ifndef SUBTRACTIVE_LAGGED_RANDOM_CORE_ASSERT_SVH
`define SUBTRACTIVE_LAGGED_RANDOM_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("subtractive random core: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("subtractive random core: next-cycle check failed");

`endif

// ----- rtl/core/slr_pkg.sv -----
// ----------------------------------------------------------------------------
// Subtractive random core package
// Widths, constants, shared types, the wrapping subtract and the cursor advance of the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

	localparam int unsigned ValW   = 30;
	localparam int unsigned SeedW  = 28;
	localparam int unsigned PosW   = 6;
	localparam int unsigned TblDepth = 56;

	localparam logic [ValW-1:0]  Modulus  = 30'd1000000000;
	localparam logic [SeedW-1:0] SeedBase = 28'd161803398;
	localparam logic [PosW-1:0]  TableLen = 6'd55;
	localparam logic [PosW-1:0]  Scatter  = 6'd21;
	localparam logic [PosW-1:0]  LagGap   = 6'd31;
	// Warm-up partner of entry i is 1 + (i + 30) mod 55, that is i + 31 with wrap.
	localparam logic [PosW-1:0]  WarmStep = 6'd31;
	localparam logic [1:0]       LastPass = 2'd3;

	typedef logic [ValW-1:0] val_t;
	typedef logic [PosW-1:0] pos_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_FILL,
		ST_WARM_RD,
		ST_WARM_WR,
		ST_DRAW_RD,
		ST_DRAW_WR
	} state_t;

	typedef struct packed {
		logic en;
		pos_t addr;
		val_t data;
	} tbl_wr_t;

	typedef struct packed {
		pos_t addr_a;
		pos_t addr_b;
	} tbl_rd_t;

	// a - b, wrapped into 0 .. Modulus-1 when it borrows.
	function automatic val_t sub_wrap(input val_t a, input val_t b);
		logic [ValW:0] diff;
		diff = {1'b0, a} - {1'b0, b};
		if (diff[ValW]) begin
			diff = diff + {1'b0, Modulus};
		end
		return diff[ValW-1:0];
	endfunction

	// Cursor advance over positions 1..55; anything else restarts at 1.
	function automatic pos_t next_pos(input pos_t p);
		pos_t r;
		if (p >= TableLen || p == '0) begin
			r = pos_t'(1);
		end else begin
			r = p + pos_t'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/subtractive_lagged_random_core.sv -----
// ----------------------------------------------------------------------------
// Subtractive lagged random core
// Lagged subtractive generator modulo 10^9 over a 55-entry table, driven by a
// small sequencer around one shared wrapping subtractor.
// ----------------------------------------------------------------------------
// A plain draw reads the table in DRAW_RD, writes it in DRAW_WR and raises strobe
// once back in IDLE; busy is low again in that cycle, so a new draw can be taken then.
// A reseed (or the first draw after reset) first runs a seed step, a fill of 54
// entries and 4 warm-up passes of 55 entries, each entry a read then a write of the
// table memory. The receiver cannot stall.
// Reset clears the sequencer, cursors and seeded flag, not the table memory.
`timescale 1ns / 1ps
`default_nettype none

module subtractive_lagged_random_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       action,
	input  wire logic [slr_pkg::SeedW-1:0] seed,
	output logic                            busy,
	output logic                            strobe,
	output logic [slr_pkg::ValW-1:0]        value
);
	import slr_pkg::*;

	state_t  state_q, state_d;
	tbl_wr_t wr;
	tbl_rd_t rd;
	val_t    rd_a, rd_b;
	val_t    op_a, op_b, unit_y;

	logic [SeedW-1:0] seed_q;
	logic [SeedW-1:0] seed_abs;
	val_t    cur_q, prev_q, value_q;
	pos_t    pos_q, cnt_q, read_q, lag_q;
	pos_t    pos_step, warm_j;
	logic [PosW:0] pos_sum, warm_sum;
	logic [1:0] pass_q;
	logic    seeded_q, strobe_q;

	slr_table u_table (
		.clk  (clk),
		.wr   (wr),
		.rd   (rd),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	// The one arithmetic unit, shared by fill, warm-up and draw.
	assign unit_y = sub_wrap(op_a, op_b);

	assign seed_abs = (seed_q > SeedBase) ? (seed_q - SeedBase) : (SeedBase - seed_q);

	assign pos_sum  = {1'b0, pos_q} + {1'b0, Scatter};
	assign pos_step = (pos_sum >= {1'b0, TableLen}) ? pos_t'(pos_sum - {1'b0, TableLen})
	                                                : pos_sum[PosW-1:0];
	assign warm_sum = {1'b0, cnt_q} + {1'b0, WarmStep};
	assign warm_j   = (warm_sum > {1'b0, TableLen}) ? pos_t'(warm_sum - {1'b0, TableLen})
	                                                : warm_sum[PosW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		wr      = '0;
		rd      = '0;
		op_a    = '0;
		op_b    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (action || !seeded_q) ? ST_SEED : ST_DRAW_RD;
				end
			end
			ST_SEED: begin
				wr      = '{en: 1'b1, addr: TableLen, data: val_t'(seed_abs)};
				state_d = ST_FILL;
			end
			ST_FILL: begin
				wr   = '{en: 1'b1, addr: pos_q, data: prev_q};
				op_a = cur_q;
				op_b = prev_q;
				if (cnt_q == TableLen - pos_t'(1)) begin
					state_d = ST_WARM_RD;
				end
			end
			ST_WARM_RD: begin
				rd      = '{addr_a: cnt_q, addr_b: warm_j};
				state_d = ST_WARM_WR;
			end
			ST_WARM_WR: begin
				op_a = rd_a;
				op_b = rd_b;
				wr   = '{en: 1'b1, addr: cnt_q, data: unit_y};
				if (cnt_q == TableLen && pass_q == LastPass) begin
					state_d = ST_DRAW_RD;
				end else begin
					state_d = ST_WARM_RD;
				end
			end
			ST_DRAW_RD: begin
				rd      = '{addr_a: next_pos(read_q), addr_b: next_pos(lag_q)};
				state_d = ST_DRAW_WR;
			end
			ST_DRAW_WR: begin
				op_a    = rd_a;
				op_b    = rd_b;
				wr      = '{en: 1'b1, addr: read_q, data: unit_y};
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			read_q   <= '0;
			lag_q    <= '0;
			cnt_q    <= '0;
			pass_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_DRAW_WR);
			unique case (state_q)
				ST_SEED: begin
					cnt_q <= pos_t'(1);
				end
				ST_FILL: begin
					if (cnt_q == TableLen - pos_t'(1)) begin
						cnt_q  <= pos_t'(1);
						pass_q <= '0;
					end else begin
						cnt_q <= cnt_q + pos_t'(1);
					end
				end
				ST_WARM_WR: begin
					if (cnt_q == TableLen) begin
						cnt_q  <= pos_t'(1);
						pass_q <= pass_q + 2'd1;
						if (pass_q == LastPass) begin
							// Seeding done: cursors restart 31 apart.
							read_q   <= '0;
							lag_q    <= LagGap;
							seeded_q <= 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + pos_t'(1);
					end
				end
				ST_DRAW_RD: begin
					read_q <= next_pos(read_q);
					lag_q  <= next_pos(lag_q);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			seed_q <= seed;
		end
		if (state_q == ST_SEED) begin
			cur_q  <= val_t'(seed_abs);
			prev_q <= val_t'(1);
			pos_q  <= Scatter;
		end
		if (state_q == ST_FILL) begin
			prev_q <= unit_y;
			cur_q  <= prev_q;
			pos_q  <= pos_step;
		end
		if (state_q == ST_DRAW_WR) begin
			value_q <= unit_y;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign value  = value_q;

endmodule

`default_nettype wire

// ----- rtl/core/slr_table.sv -----
// ----------------------------------------------------------------------------
// Lag table
// 56-entry table memory with positions 1..55 in use, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slr_table (
	input  wire logic            clk,
	input  wire slr_pkg::tbl_wr_t wr,
	input  wire slr_pkg::tbl_rd_t rd,
	output slr_pkg::val_t        rd_a,
	output slr_pkg::val_t        rd_b
);
	import slr_pkg::*;

	// Position 0 is never written and its read data is never used.
	val_t mem [0:TblDepth-1];
	val_t rd_a_q;
	val_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_a_q <= mem[rd.addr_a];
		rd_b_q <= mem[rd.addr_b];
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

`default_nettype wire

// ----- rtl/core/slr_checker.sv -----
// ----------------------------------------------------------------------------
// Subtractive random core checker
// Port-level checks of the start/busy/strobe sequence and of the value range, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "subtractive_lagged_random_core_assert.svh"

module slr_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic                       strobe,
	input wire logic [slr_pkg::ValW-1:0]  value
);
	import slr_pkg::*;

	// A start transfer keeps the block occupied in the following cycle.
	`SLR_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// A result only appears once the item's work is finished.
	`SLR_ASSERT_NOW(a_strobe_free, clk, arst_n, strobe, !busy)
	// A result is never followed directly by a second one.
	`SLR_ASSERT_NEXT(a_strobe_single, clk, arst_n, strobe, !strobe)
	// Every draw is a residue modulo 10^9.
	`SLR_ASSERT_NOW(a_value_range, clk, arst_n, strobe, value < Modulus)

endmodule

bind subtractive_lagged_random_core slr_checker u_slr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.value  (value)
);

`default_nettype wire

// ----- sim/slr_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subtractive random core test package
// Item codes shared by the stimulus side and the checker of the core.
// ----------------------------------------------------------------------------

package slr_tb_pkg;

	typedef enum logic {
		ACT_DRAW   = 1'b0,
		ACT_RESEED = 1'b1
	} slr_action_e;

endpackage

// ----- sim/subtractive_lagged_random_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subtractive random core checker
// Watches the start transfers and the result strobe of the core, keeps its own
// copy of the 55-entry lagged table and compares each draw with its prediction.
// ----------------------------------------------------------------------------

module subtractive_lagged_random_checker
	import slr_pkg::*;
	import slr_tb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire logic             action,
	input  wire logic [SeedW-1:0] seed,
	input  wire logic             strobe,
	input  wire logic [ValW-1:0]  value,
	output int                    fail_count,
	output int                    outstanding
);

	localparam int WarmPasses = int'(LastPass) + 1;

	val_t draw_tbl [0:TblDepth-1];
	pos_t read_pos;
	pos_t lag_pos;
	logic is_seeded;
	val_t expected_q [$];
	val_t want;

	function automatic val_t mod_sub(input val_t a, input val_t b);
		int unsigned d;
		if (a >= b) begin
			d = int'(a) - int'(b);
		end else begin
			d = int'(a) + int'(Modulus) - int'(b);
		end
		return val_t'(d);
	endfunction

	function automatic pos_t step_pos(input pos_t p);
		pos_t r;
		if (p == '0 || p >= TableLen) begin
			r = pos_t'(1);
		end else begin
			r = p + pos_t'(1);
		end
		return r;
	endfunction

	function automatic void reseed_table(input logic [SeedW-1:0] s);
		int unsigned cur;
		int unsigned prev;
		int unsigned pos;
		int unsigned partner;
		if (s > SeedBase) begin
			cur = int'(s) - int'(SeedBase);
		end else begin
			cur = int'(SeedBase) - int'(s);
		end
		cur = cur % int'(Modulus);
		draw_tbl[TableLen] = val_t'(cur);
		prev = 1;
		// The fill walks the table in the scattered order 21*i mod 55.
		for (int i = 1; i < int'(TableLen); i++) begin
			pos = (int'(Scatter) * i) % int'(TableLen);
			draw_tbl[pos_t'(pos)] = val_t'(prev);
			prev = 32'(mod_sub(val_t'(cur), val_t'(prev)));
			cur = 32'(draw_tbl[pos_t'(pos)]);
		end
		for (int k = 0; k < WarmPasses; k++) begin
			for (int i = 1; i <= int'(TableLen); i++) begin
				partner = (i + int'(WarmStep) - 1) % int'(TableLen) + 1;
				draw_tbl[pos_t'(i)] = mod_sub(draw_tbl[pos_t'(i)],
					draw_tbl[pos_t'(partner)]);
			end
		end
		read_pos  = '0;
		lag_pos   = LagGap;
		is_seeded = 1'b1;
	endfunction

	function automatic val_t predict_draw(input logic act, input logic [SeedW-1:0] s);
		val_t v;
		// A draw that comes before any seeding seeds the table first.
		if (act == ACT_RESEED || !is_seeded) begin
			reseed_table(s);
		end
		read_pos = step_pos(read_pos);
		lag_pos  = step_pos(lag_pos);
		v = mod_sub(draw_tbl[read_pos], draw_tbl[lag_pos]);
		draw_tbl[read_pos] = v;
		return v;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			read_pos  = '0;
			lag_pos   = '0;
			is_seeded = 1'b0;
			expected_q.delete();
		end else begin
			// A new start can be taken at the same edge as the older result,
			// so the result is retired before the new prediction is queued.
			if (strobe) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with no draw pending: expected none, actual %0d",
						$time, value);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (value !== want) begin
						$display("%0t: value mismatch: expected %0d, actual %0d",
							$time, want, value);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				expected_q.push_back(predict_draw(action, seed));
			end
		end
		outstanding = expected_q.size();
	end

endmodule

// ----- sim/tb_subtractive_lagged_random_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subtractive random core testbench
// Drives directed and random draw and reseed requests into the core with
// varying sender gaps; a checker beside the core predicts every draw.
// ----------------------------------------------------------------------------

module tb_subtractive_lagged_random_core;
	import slr_pkg::*;
	import slr_tb_pkg::*;

	localparam int QuietLimit     = 4000;
	localparam int DrainCycles    = 16;
	localparam int RandomPerPhase = 630;
	localparam int ReseedPct      = 3;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             action;
	logic [SeedW-1:0] seed;
	logic             busy;
	logic             strobe;
	logic [ValW-1:0]  value;

	int fail_count;
	int outstanding;
	int quiet_cycles = 0;
	int idle_pct     = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	subtractive_lagged_random_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.seed   (seed),
		.busy   (busy),
		.strobe (strobe),
		.value  (value)
	);

	subtractive_lagged_random_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.seed        (seed),
		.strobe      (strobe),
		.value       (value),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic issue(input slr_action_e act, input logic [SeedW-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start  <= 1'b1;
		action <= act;
		seed   <= s;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	function automatic logic [SeedW-1:0] pick_seed();
		logic [SeedW-1:0] r;
		case ($urandom_range(3))
			0: begin
				r = SeedW'($urandom);
			end
			1: begin
				r = SeedW'(SeedBase - 3 + $urandom_range(6));
			end
			2: begin
				r = SeedW'($urandom_range(int'(SeedBase)));
			end
			default: begin
				case ($urandom_range(2))
					0: r = '0;
					1: r = '1;
					default: r = SeedBase;
				endcase
			end
		endcase
		return r;
	endfunction

	function automatic slr_action_e pick_action();
		slr_action_e a;
		if ($urandom_range(99) < ReseedPct) begin
			a = ACT_RESEED;
		end else begin
			a = ACT_DRAW;
		end
		return a;
	endfunction

	always @(posedge clk) begin
		if ((start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		action = ACT_DRAW;
		seed   = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// The first draw arrives unseeded and must seed from its own field.
		issue(ACT_DRAW, '0);
		issue(ACT_DRAW, '1);
		issue(ACT_DRAW, '0);
		issue(ACT_DRAW, pick_seed());
		// Seed equal to the base gives a zero starting value.
		issue(ACT_RESEED, SeedBase);
		issue(ACT_DRAW, '1);
		issue(ACT_DRAW, '0);
		// Seeds above the base take the absolute difference.
		issue(ACT_RESEED, '1);
		issue(ACT_DRAW, '0);
		issue(ACT_RESEED, SeedW'(SeedBase + 1));
		issue(ACT_DRAW, '1);
		issue(ACT_RESEED, '0);
		issue(ACT_DRAW, '0);
		issue(ACT_RESEED, SeedW'(SeedBase - 1));
		issue(ACT_RESEED, 28'h5555555);
		issue(ACT_RESEED, 28'hAAAAAAA);
		for (int i = 0; i < 6; i++) begin
			issue(ACT_DRAW, pick_seed());
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: idle_pct = 6;
				1: idle_pct = 85;
				default: idle_pct = 0;
			endcase
			for (int i = 0; i < RandomPerPhase; i++) begin
				issue(pick_action(), pick_seed());
			end
		end

		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		if (fail_count == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
